/* rtl/fee_pkg.sv */
// Shared types, constants and helper functions for the filename escape encoder.
package fee_pkg;

  // Name and symbol geometry
  localparam int SYMBOL_BITS    = 12;
  localparam int NAME_MAX_BYTES = 255;
  localparam int ACC_W          = 21;
  localparam int CNT_W          = 5;
  localparam int CP_W           = 16;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Code point base and UTF-8 framing bytes
  localparam logic [CP_W-1:0] SYM_BASE    = 16'h4E00;
  localparam logic [7:0]      UTF8_LEAD   = 8'hE0;
  localparam logic [7:0]      UTF8_CONT   = 8'h80;
  localparam logic [7:0]      UTF8_LOW6   = 8'h3F;
  localparam logic [7:0]      UTF8_LOW4   = 8'h0F;
  localparam logic [7:0]      CHAR_SLASH  = 8'h2F;
  localparam logic [7:0]      CHAR_DOT    = 8'h2E;
  localparam logic [7:0]      CHAR_NUL    = 8'h00;
  localparam logic [3:0]      PREFIX_MAX  = 4'd8;

  // Configuration register indexes
  localparam logic [1:0] REG_PREFIX_BYTES  = 2'd0;
  localparam logic [1:0] REG_PREFIX_LENGTH = 2'd1;
  localparam logic [1:0] REG_HEX_LIMIT     = 2'd2;

  // Output segments of one job, in emission order
  localparam int         NSEG       = 6;
  localparam logic [2:0] SEG_PREFIX = 3'd0;
  localparam logic [2:0] SEG_LSYM   = 3'd1;
  localparam logic [2:0] SEG_HEX    = 3'd2;
  localparam logic [2:0] SEG_SYMA   = 3'd3;
  localparam logic [2:0] SEG_SYMB   = 3'd4;
  localparam logic [2:0] SEG_ZERO   = 3'd5;

  typedef struct packed {
    logic [63:0] prefix_bytes;
    logic [3:0]  prefix_length;
    logic [7:0]  hex_limit;
  } fee_cfg_t;

  // One classified item, ready to be spelled out byte by byte
  typedef struct packed {
    logic [NSEG-1:0] mask;
    logic [7:0]      hex_byte;
    logic [CP_W-1:0] lsym_cp;
    logic [CP_W-1:0] syma_cp;
    logic [CP_W-1:0] symb_cp;
    logic            last;
    logic            status;
  } fee_job_t;

  // Lower-case hex character for one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = 8'h30 + {4'h0, nib};
    else             c = 8'h57 + {4'h0, nib};
    return c;
  endfunction

  // Code point for a symbol value
  function automatic logic [CP_W-1:0] sym_cp(input logic [SYMBOL_BITS-1:0] v);
    return SYM_BASE + CP_W'(v);
  endfunction

  // Byte k of the three-byte UTF-8 spelling of a code point
  function automatic logic [7:0] sym_byte(input logic [CP_W-1:0] cp, input logic [1:0] k);
    logic [7:0] b;
    case (k)
      2'd0:    b = UTF8_LEAD | ({4'h0, cp[15:12]} & UTF8_LOW4);
      2'd1:    b = UTF8_CONT | ({2'b00, cp[11:6]} & UTF8_LOW6);
      default: b = UTF8_CONT | ({2'b00, cp[5:0]} & UTF8_LOW6);
    endcase
    return b;
  endfunction

endpackage

/* rtl/fee_front.sv */
// Front end: accepts name bytes, tracks per-name state and builds output jobs.
module fee_front (
  input  logic              clk,
  input  logic              rst_n,
  input  fee_pkg::fee_cfg_t cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_name_byte,
  input  logic [7:0]        in_name_length,
  input  logic              q_full,
  output logic              q_push,
  output fee_pkg::fee_job_t q_job
);
  import fee_pkg::*;

  localparam logic [CNT_W-1:0] SB_C = CNT_W'(SYMBOL_BITS);

  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       pos_r, pos_nxt;
  logic             inv_r, inv_nxt;
  logic             fwd_r, fwd_nxt;

  logic             accept, first, last, hex_tier, zero_len;
  logic [8:0]       pos_inc;
  logic [ACC_W-1:0] acc_sh, acc_a;
  logic [CNT_W-1:0] cnt_sum, cnt_a;
  logic             sym_full, pad;
  logic [SYMBOL_BITS-1:0] syma_val, padv, lsym_val;
  logic             bad_byte, dot_name;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Item classification
  always_comb begin
    zero_len = (in_name_length == 8'd0);
    pos_inc  = {1'b0, pos_r} + 9'd1;
    first    = (pos_r == 8'd0);
    last     = (pos_inc >= {1'b0, in_name_length});
    hex_tier = (in_name_length <= cfg.hex_limit);
  end

  // Bit grouping for the symbol tier; at most one full group per byte
  always_comb begin
    acc_sh   = {acc_r[ACC_W-9:0], in_name_byte};
    cnt_sum  = cnt_r + CNT_W'(8);
    sym_full = (cnt_sum >= SB_C);
    cnt_a    = sym_full ? cnt_sum - SB_C : cnt_sum;
    syma_val = SYMBOL_BITS'(acc_sh >> cnt_a);
    acc_a    = acc_sh & ((ACC_W'(1) << cnt_a) - ACC_W'(1));
    pad      = last && (cnt_a != '0);
    padv     = SYMBOL_BITS'(acc_a << (SB_C - cnt_a));
    lsym_val = SYMBOL_BITS'(in_name_length);
  end

  // Validity tracking
  always_comb begin
    bad_byte = (in_name_byte == CHAR_SLASH) || (in_name_byte == CHAR_NUL) ||
               (in_name_length > 8'(NAME_MAX_BYTES));
    dot_name = last && (in_name_byte == CHAR_DOT) &&
               (((pos_r == 8'd0) && (in_name_length == 8'd1)) ||
                ((pos_r == 8'd1) && (in_name_length == 8'd2) && fwd_r));
    inv_nxt  = inv_r || bad_byte || dot_name;
  end

  // Job assembly
  always_comb begin
    q_job          = '0;
    q_job.hex_byte = in_name_byte;
    q_job.lsym_cp  = sym_cp(lsym_val);
    q_job.syma_cp  = sym_cp(syma_val);
    q_job.symb_cp  = sym_cp(padv);
    if (zero_len) begin
      q_job.mask[SEG_ZERO] = 1'b1;
      q_job.last           = 1'b1;
      q_job.status         = 1'b1;
    end else begin
      q_job.mask[SEG_PREFIX] = first && (cfg.prefix_length != 4'd0);
      q_job.mask[SEG_LSYM]   = first && !hex_tier;
      q_job.mask[SEG_HEX]    = hex_tier;
      q_job.mask[SEG_SYMA]   = !hex_tier && sym_full;
      q_job.mask[SEG_SYMB]   = !hex_tier && pad;
      q_job.last             = last;
      q_job.status           = inv_nxt;
    end
    // items that only feed the accumulator produce no job
    q_push = accept && (q_job.mask != '0);
  end

  // Per-name state update
  always_comb begin
    acc_nxt = acc_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    fwd_nxt = fwd_r;
    if (accept) begin
      if (zero_len || last) begin
        acc_nxt = '0;
        cnt_nxt = '0;
        pos_nxt = '0;
        fwd_nxt = 1'b0;
      end else begin
        pos_nxt = pos_r + 8'd1;
        if (!hex_tier) begin
          acc_nxt = acc_a;
          cnt_nxt = cnt_a;
        end
        if (first && (in_name_byte == CHAR_DOT)) fwd_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      cnt_r <= '0;
      pos_r <= '0;
      inv_r <= 1'b0;
      fwd_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
      fwd_r <= fwd_nxt;
      if (accept) inv_r <= (zero_len || last) ? 1'b0 : inv_nxt;
    end
  end

endmodule

/* rtl/fee_queue.sv */
// Short job queue between the front end and the back end.
module fee_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  fee_pkg::fee_job_t push_job,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output fee_pkg::fee_job_t head_job
);
  import fee_pkg::*;

  fee_job_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_pop;

  assign full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_job   = slot_r[rd_r];
  assign do_pop     = pop && head_valid;

  // Pointer and fill count
  always_comb begin
    wr_nxt  = push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = do_pop ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_job;
  end

endmodule

/* rtl/fee_back.sv */
// Back end: spells each job out one byte per cycle into the output register, while the receiver takes them.
module fee_back (
  input  logic              clk,
  input  logic              rst_n,
  input  fee_pkg::fee_cfg_t cfg,
  input  logic              q_valid,
  input  fee_pkg::fee_job_t q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last_of_name,
  output logic              out_status
);
  import fee_pkg::*;

  logic            busy_r, busy_nxt;
  fee_job_t        job_r, job_nxt;
  logic [NSEG-1:0] rem_r, rem_nxt, rem_after;
  logic [2:0]      idx_r, idx_nxt;

  logic            ov_r, ov_nxt;
  logic [7:0]      ob_r, ob_nxt;
  logic            ol_r, ol_nxt;
  logic            os_r, os_nxt;

  logic [2:0]      seg;
  logic [2:0]      seg_last_idx;
  logic [3:0]      plen;
  logic [7:0]      cur_byte;
  logic            can_emit, seg_done, job_done;

  assign out_valid        = ov_r;
  assign out_byte         = ob_r;
  assign out_last_of_name = ol_r;
  assign out_status       = os_r;

  // Current segment: lowest pending one
  always_comb begin
    seg = SEG_ZERO;
    for (int i = NSEG - 1; i >= 0; i--) begin
      if (rem_r[i]) seg = 3'(i);
    end
  end

  // Byte for the current segment and position
  always_comb begin
    plen = (cfg.prefix_length > PREFIX_MAX) ? PREFIX_MAX : cfg.prefix_length;
    case (seg)
      SEG_PREFIX: begin
        seg_last_idx = 3'(plen - 4'd1);
        cur_byte     = cfg.prefix_bytes[{3'd7 - idx_r, 3'b000} +: 8];
      end
      SEG_LSYM: begin
        seg_last_idx = 3'd2;
        cur_byte     = sym_byte(job_r.lsym_cp, idx_r[1:0]);
      end
      SEG_HEX: begin
        seg_last_idx = 3'd1;
        cur_byte     = (idx_r == 3'd0) ? hex_char(job_r.hex_byte[7:4])
                                       : hex_char(job_r.hex_byte[3:0]);
      end
      SEG_SYMA: begin
        seg_last_idx = 3'd2;
        cur_byte     = sym_byte(job_r.syma_cp, idx_r[1:0]);
      end
      SEG_SYMB: begin
        seg_last_idx = 3'd2;
        cur_byte     = sym_byte(job_r.symb_cp, idx_r[1:0]);
      end
      default: begin
        seg_last_idx = 3'd0;
        cur_byte     = 8'h00;
      end
    endcase
  end

  // Sequencing and job load
  always_comb begin
    can_emit  = busy_r && (!ov_r || out_ready);
    seg_done  = (idx_r == seg_last_idx);
    rem_after = rem_r;
    if (seg_done) rem_after[seg] = 1'b0;
    job_done  = can_emit && seg_done && (rem_after == '0);
    q_pop     = q_valid && (!busy_r || job_done);

    busy_nxt = busy_r;
    job_nxt  = job_r;
    rem_nxt  = rem_r;
    idx_nxt  = idx_r;
    if (q_pop) begin
      busy_nxt = 1'b1;
      job_nxt  = q_job;
      rem_nxt  = q_job.mask;
      idx_nxt  = '0;
    end else if (job_done) begin
      busy_nxt = 1'b0;
    end else if (can_emit) begin
      rem_nxt = rem_after;
      idx_nxt = seg_done ? 3'd0 : idx_r + 3'd1;
    end
  end

  // Output register: a transfer frees it for the next byte
  always_comb begin
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    ol_nxt = ol_r;
    os_nxt = os_r;
    if (can_emit) begin
      ov_nxt = 1'b1;
      ob_nxt = cur_byte;
      ol_nxt = job_done && job_r.last;
      os_nxt = job_done && job_r.last && job_r.status;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rem_r  <= '0;
      idx_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      rem_r  <= rem_nxt;
      idx_r  <= idx_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
    os_r  <= os_nxt;
  end

endmodule

/* rtl/filename_escape_encoder_unit.sv */
// Top level of the filename escape encoder: configuration registers and the front/back pipeline.
//
// Escapes one file name per run of input transfers: each name byte arrives with the
// name's total length, and the block emits the configured prefix followed by either two
// lower-case hex characters per byte (names up to hex_limit bytes) or a length symbol and
// 12-bit groups of the name's bits, each as a three-byte UTF-8 code point from 0x4E00.
// The final byte of a name carries last_of_name and the validity status; a zero-length
// item yields a single 0x00 byte marked last and invalid. The back end writes one output
// byte per cycle while the receiver takes them, so a name byte yields two output bytes in
// the hex tier and zero, three or six in the symbol tier (two on average at 12 bits per
// group); the first byte of a name adds one output byte per prefix byte, plus three for
// the length symbol in the symbol tier. The front end takes one input transfer per cycle
// while its four-entry job queue has room, so input and output stall independently.
// Configuration writes take effect at once and are expected only while the block is idle.
module filename_escape_encoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_name_byte,
  input  logic [7:0]  in_name_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_last_of_name,
  output logic        out_status
);
  import fee_pkg::*;

  fee_cfg_t cfg_r;
  fee_job_t push_job, head_job;
  logic     q_full, q_push, q_pop, q_valid;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.prefix_bytes  <= '0;
      cfg_r.prefix_length <= '0;
      cfg_r.hex_limit     <= 8'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PREFIX_BYTES:  cfg_r.prefix_bytes  <= cfg_wdata;
        REG_PREFIX_LENGTH: cfg_r.prefix_length <= cfg_wdata[3:0];
        REG_HEX_LIMIT:     cfg_r.hex_limit     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  fee_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_name_byte   (in_name_byte),
    .in_name_length (in_name_length),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_job          (push_job)
  );

  fee_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  fee_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_valid          (q_valid),
    .q_job            (head_job),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_name (out_last_of_name),
    .out_status       (out_status)
  );

endmodule

/* rtl/fee_checker.sv */
// Port-level checker for the filename escape encoder, bound to the top level.
module fee_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_last_of_name,
  input logic        out_status
);

  // A stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
      $stable(out_last_of_name) && $stable(out_status))
    else $error("output changed while stalled");

  // Invalid status only appears on the last byte of a name
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_last_of_name)
    else $error("status set on a byte that is not last");

  // Reset leaves no result pending
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // Reset empties the job queue so input is taken at once
  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

endmodule

bind filename_escape_encoder_unit fee_checker u_fee_checker (.*);

/* dv/tb_top.sv */
// Self-checking testbench for the filename escape encoder: directed cases, then random names.
module tb_top;
  import fee_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 280;
  localparam int MAX_REPORTS  = 40;
  localparam int END_WAIT_MAX = 100000;
  localparam int RUN_LIMIT    = 2000000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       status;
  } escaped_byte_t;

  // DUT ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_PREFIX_BYTES;
  logic [63:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_name_byte = '0;
  logic [7:0]  in_name_length = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_byte;
  logic        out_last_of_name;
  logic        out_status;

  // Expected output bytes, oldest first
  escaped_byte_t escaped_q[$];

  // Mirror of the configuration registers
  logic [63:0] mirror_prefix_bytes = '0;
  logic [3:0]  mirror_prefix_length = '0;
  logic [7:0]  mirror_hex_limit = 8'd16;

  // Mirror of the per-name state
  logic [20:0] pending_bits = '0;
  int unsigned pending_count = 0;
  int unsigned name_pos = 0;
  bit          name_invalid = 1'b0;
  bit          name_dot_first = 1'b0;

  string hex_alphabet = "0123456789abcdef";

  int error_count = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  filename_escape_encoder_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_name_byte     (in_name_byte),
    .in_name_length   (in_name_length),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_byte         (out_byte),
    .out_last_of_name (out_last_of_name),
    .out_status       (out_status)
  );

  // Clock, period 2
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit
  initial begin
    #(RUN_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Escape predictor
  // ---------------------------------------------------------------------------
  function automatic void push_escaped_byte(input logic [7:0] d);
    escaped_byte_t e;
    e.data   = d;
    e.last   = 1'b0;
    e.status = 1'b0;
    escaped_q.push_back(e);
  endfunction

  // Three-byte UTF-8 spelling of SYM_BASE + value
  function automatic void push_symbol_bytes(input logic [11:0] value);
    logic [15:0] cp;
    cp = SYM_BASE + {4'h0, value};
    push_escaped_byte(UTF8_LEAD | {4'h0, cp[15:12]});
    push_escaped_byte(UTF8_CONT | {2'b00, cp[11:6]});
    push_escaped_byte(UTF8_CONT | {2'b00, cp[5:0]});
  endfunction

  function automatic void clear_name_state();
    pending_bits   = '0;
    pending_count  = 0;
    name_pos       = 0;
    name_invalid   = 1'b0;
    name_dot_first = 1'b0;
  endfunction

  function automatic void predict_escape(input logic [7:0] b, input logic [7:0] len);
    bit            first_item;
    bit            last_item;
    int unsigned   plen;
    escaped_byte_t tail;
    if (len == 8'd0) begin
      tail.data   = 8'h00;
      tail.last   = 1'b1;
      tail.status = 1'b1;
      escaped_q.push_back(tail);
      clear_name_state();
      return;
    end
    first_item = (name_pos == 0);
    last_item  = (name_pos + 1 >= len);

    // Prefix and, in the symbol tier, the length symbol open each name
    if (first_item) begin
      plen = (mirror_prefix_length > PREFIX_MAX) ? PREFIX_MAX : mirror_prefix_length;
      for (int i = 0; i < plen; i++) push_escaped_byte(mirror_prefix_bytes[63 - 8*i -: 8]);
      if (len > mirror_hex_limit) push_symbol_bytes(12'(len));
      if (b == CHAR_DOT) name_dot_first = 1'b1;
    end

    // Validity
    if (b == CHAR_SLASH || b == CHAR_NUL || int'(len) > NAME_MAX_BYTES) name_invalid = 1'b1;
    if (last_item && b == CHAR_DOT) begin
      if (name_pos == 0 && len == 8'd1) name_invalid = 1'b1;
      if (name_pos == 1 && len == 8'd2 && name_dot_first) name_invalid = 1'b1;
    end

    // Payload tier
    if (len <= mirror_hex_limit) begin
      push_escaped_byte(hex_alphabet[b[7:4]]);
      push_escaped_byte(hex_alphabet[b[3:0]]);
    end else begin
      pending_bits  = {pending_bits[12:0], b};
      pending_count = pending_count + 8;
      while (pending_count >= SYMBOL_BITS) begin
        pending_count = pending_count - SYMBOL_BITS;
        push_symbol_bytes(12'(pending_bits >> pending_count));
        pending_bits = pending_bits & ((21'd1 << pending_count) - 21'd1);
      end
      if (last_item && pending_count > 0)
        push_symbol_bytes(12'(pending_bits << (SYMBOL_BITS - pending_count)));
    end

    if (last_item) begin
      tail = escaped_q.pop_back();
      tail.last   = 1'b1;
      tail.status = name_invalid;
      escaped_q.push_back(tail);
      clear_name_state();
    end else begin
      name_pos = (name_pos + 1) & 255;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output checker and receiver stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin : check_output
    escaped_byte_t exp_b;
    if (rst_n && out_valid && out_ready) begin
      if (escaped_q.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b status %0b",
                                  out_byte, out_last_of_name, out_status));
      end else begin
        exp_b = escaped_q.pop_front();
        if (out_byte !== exp_b.data)
          report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, exp_b.data));
        if (out_last_of_name !== exp_b.last)
          report_mismatch($sformatf("out_last_of_name %0b, expected %0b (byte %02h)",
                                    out_last_of_name, exp_b.last, exp_b.data));
        if (out_status !== exp_b.status)
          report_mismatch($sformatf("out_status %0b, expected %0b (byte %02h)",
                                    out_status, exp_b.status, exp_b.data));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // One input transfer; valid stays high on return so the next item can follow at once
  task automatic send_item(input logic [7:0] b, input logic [7:0] len);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_name_byte   <= b;
    in_name_length <= len;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_escape(b, len);
    items_sent++;
  endtask

  // Drop valid, wait for all expected bytes, then let zero-output items drain
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (escaped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_PREFIX_BYTES)       mirror_prefix_bytes  = data;
    else if (idx == REG_PREFIX_LENGTH) mirror_prefix_length = data[3:0];
    else if (idx == REG_HEX_LIMIT)     mirror_hex_limit     = data[7:0];
  endtask

  task automatic configure(input logic [63:0] pbytes, input logic [63:0] plen,
                           input logic [63:0] hlimit);
    wait_idle();
    write_reg(REG_PREFIX_BYTES, pbytes);
    write_reg(REG_PREFIX_LENGTH, plen);
    write_reg(REG_HEX_LIMIT, hlimit);
  endtask

  // Mostly random bytes, with dots, slashes and zeros now and then
  function automatic logic [7:0] pick_name_byte();
    case ($urandom_range(0, 19))
      0:       return CHAR_DOT;
      1:       return CHAR_SLASH;
      2:       return CHAR_NUL;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_name(input int unsigned len);
    for (int i = 0; i < len; i++) send_item(pick_name_byte(), 8'(len));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset values: no prefix, hex tier up to 16 bytes
  task automatic test_hex_defaults();
    send_item(8'h61, 8'd1);
    send_item(8'hFF, 8'd2);
    send_item(8'h00, 8'd2);
  endtask

  task automatic test_zero_length();
    send_item(8'hA5, 8'd0);
    send_item(8'h5A, 8'd0);
  endtask

  // Dot names are invalid, a dot elsewhere is not; slash is invalid
  task automatic test_dot_and_slash();
    send_item(CHAR_DOT, 8'd1);
    send_item(CHAR_DOT, 8'd2);
    send_item(CHAR_DOT, 8'd2);
    send_item(CHAR_DOT, 8'd2);
    send_item(8'h61, 8'd2);
    send_item(8'h61, 8'd2);
    send_item(CHAR_SLASH, 8'd2);
  endtask

  // Full prefix with a saturating length, everything in the symbol tier
  task automatic test_prefix_symbol_tier();
    configure(64'h0123_4567_89AB_CDEF, 64'd15, 64'd0);
    write_reg(REG_UNUSED, '1);
    send_item(8'hFF, 8'd1);
    send_item(8'h80, 8'd2);
    send_item(8'h7F, 8'd2);
  endtask

  // Names cut short by a smaller length, and tier changes inside a name
  task automatic test_length_change();
    configure(64'd0, 64'd0, 64'd255);
    send_item(8'h41, 8'd200);
    send_item(8'h42, 8'd2);
    configure('1, 64'd1, 64'd16);
    send_item(8'hC3, 8'd255);
    send_item(8'h5A, 8'd2);
    for (int i = 0; i < 3; i++) send_item(pick_name_byte(), 8'd20);
    send_item(8'h3C, 8'd3);
  endtask

  task automatic test_random_names();
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    int unsigned done;
    int          start_count;
    int          names_since_cfg;
    logic [63:0] plen_word;
    logic [63:0] hlim_word;
    start_count     = items_sent;
    names_since_cfg = 5;
    while (items_sent - start_count < RANDOM_ITEMS) begin
      done = items_sent - start_count;
      // Idling phases: none, sender idle, receiver stalling, both
      case (done * 4 / RANDOM_ITEMS)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 70; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 70; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase

      // New settings every few names, random junk in the unused upper bits
      if (names_since_cfg >= 5) begin
        plen_word = {$urandom, $urandom};
        hlim_word = {$urandom, $urandom};
        plen_word[3:0] = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 5))
          0:       hlim_word[7:0] = 8'd0;
          1:       hlim_word[7:0] = 8'd255;
          2:       hlim_word[7:0] = 8'd16;
          default: hlim_word[7:0] = 8'($urandom_range(0, 30));
        endcase
        configure({$urandom, $urandom}, plen_word, hlim_word);
        names_since_cfg = 0;
      end

      kind = $urandom_range(0, 19);
      if (kind == 0) begin
        send_item(8'($urandom_range(0, 255)), 8'd0);
      end else if (kind <= 2) begin
        // Broken name: long declared length, then cut short or aborted
        len = $urandom_range(2, 255);
        cut = $urandom_range(1, (len - 1 > 6) ? 6 : len - 1);
        for (int i = 0; i < cut; i++) send_item(pick_name_byte(), 8'(len));
        if ($urandom_range(0, 3) == 0) send_item(pick_name_byte(), 8'd0);
        else send_item(pick_name_byte(), 8'($urandom_range(1, cut + 1)));
      end else if (kind == 3) begin
        // Dot-led short names
        len = $urandom_range(1, 2);
        send_item(CHAR_DOT, 8'(len));
        if (len == 2)
          send_item(($urandom_range(0, 1) != 0) ? CHAR_DOT : pick_name_byte(), 8'(len));
      end else if (kind == 4) begin
        send_name($urandom_range(25, 64));
      end else begin
        send_name($urandom_range(1, 20));
      end
      names_since_cfg++;
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : run_tests
    int waited;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_hex_defaults();
    test_zero_length();
    test_dot_and_slash();
    test_prefix_symbol_tier();
    test_length_change();
    test_random_names();

    // Drain
    in_valid <= 1'b0;
    waited = 0;
    while (escaped_q.size() != 0 && waited < END_WAIT_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (escaped_q.size() != 0)
      report_mismatch($sformatf("%0d expected bytes never arrived", escaped_q.size()));

    if (error_count == 0) $display("RESULT: OK");
    else                  $display("RESULT: ERROR");
    $finish;
  end

endmodule
